### hw/rtl/bpe_pkg.sv
// Shared widths, register indexes and pipeline control types for the Bezier point evaluator.
package bpe_pkg;

    localparam int COORD_W   = 16;
    localparam int FRAC_BITS = 16;
    localparam int PARAM_W   = FRAC_BITS + 1;
    localparam int NUM_PTS   = 4;
    localparam int NUM_REGS  = 2 * NUM_PTS;
    localparam int CFG_IDX_W = 4;
    localparam int NSTAGES   = 7;

    // Signed product of a coordinate difference and t fits in this many bits.
    localparam int PROD_W    = COORD_W + FRAC_BITS + 1;

    localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P0_X = 4'd0,
        REG_P0_Y = 4'd1,
        REG_P1_X = 4'd2,
        REG_P1_Y = 4'd3,
        REG_P2_X = 4'd4,
        REG_P2_Y = 4'd5,
        REG_P3_X = 4'd6,
        REG_P3_Y = 4'd7
    } t_reg_idx;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [NSTAGES-1:0] en;
        logic               out_valid;
        logic               in_ready;
    } t_pipe_ctl;

endpackage

### hw/rtl/bpe_cfg_regs.sv
// Control point register file written through the plain configuration port.
module bpe_cfg_regs
    import bpe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data,
    output t_coord               o_ctrl_x [NUM_PTS],
    output t_coord               o_ctrl_y [NUM_PTS]
);

    t_coord r_ctrl_x [NUM_PTS];
    t_coord r_ctrl_y [NUM_PTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PTS; k++) begin
                r_ctrl_x[k] <= '0;
                r_ctrl_y[k] <= '0;
            end
        end else if (i_cfg_we) begin
            // Writes to indexes past the last register are dropped.
            case (i_cfg_index)
                REG_P0_X: r_ctrl_x[0] <= i_cfg_data;
                REG_P0_Y: r_ctrl_y[0] <= i_cfg_data;
                REG_P1_X: r_ctrl_x[1] <= i_cfg_data;
                REG_P1_Y: r_ctrl_y[1] <= i_cfg_data;
                REG_P2_X: r_ctrl_x[2] <= i_cfg_data;
                REG_P2_Y: r_ctrl_y[2] <= i_cfg_data;
                REG_P3_X: r_ctrl_x[3] <= i_cfg_data;
                REG_P3_Y: r_ctrl_y[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_ctrl_x = r_ctrl_x;
    assign o_ctrl_y = r_ctrl_y;

endmodule

### hw/rtl/bpe_lerp.sv
// One rounded linear interpolation a + (((b - a) * t + half) >>> FRAC_BITS) over two stages.
module bpe_lerp
    import bpe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en_mul,
    input  logic               i_en_add,
    input  t_coord             i_a,
    input  t_coord             i_b,
    input  logic [PARAM_W-1:0] i_t,
    output t_coord             o_result
);

    logic signed [COORD_W:0]         diff;
    logic signed [PARAM_W:0]         t_s;
    logic signed [COORD_W+PARAM_W:0] prod_full;
    logic signed [PROD_W-1:0]        n_prod;
    logic signed [PROD_W:0]          sum;
    t_coord                          n_res;

    logic signed [PROD_W-1:0] r_prod;
    t_coord                   r_a;
    t_coord                   r_res;

    assign diff      = {i_b[COORD_W-1], i_b} - {i_a[COORD_W-1], i_a};
    assign t_s       = {1'b0, i_t};
    assign prod_full = diff * t_s;
    assign n_prod    = prod_full[PROD_W-1:0];

    // Only the low coordinate bits of the shifted sum reach the result, which
    // wraps the same way as the full-width arithmetic.
    assign sum   = {r_prod[PROD_W-1], r_prod} + ROUND_HALF;
    assign n_res = r_a + sum[FRAC_BITS +: COORD_W];

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_prod <= n_prod;
            r_a    <= i_a;
        end
        if (i_en_add) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

### hw/rtl/bpe_ctrl.sv
// Valid bits and per-stage ready chain of the evaluation pipeline.
module bpe_ctrl
    import bpe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output t_pipe_ctl o_ctl
);

    logic [NSTAGES-1:0] r_valid;
    logic [NSTAGES-1:0] n_valid;
    logic [NSTAGES:0]   rdy;

    // A stage takes new data when it is empty or its content moves on, so
    // bubbles close up behind a stalled output.
    always_comb begin
        rdy[NSTAGES] = i_out_ready;
        for (int k = NSTAGES - 1; k >= 0; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
        end
        n_valid[0] = rdy[0] ? i_in_valid : r_valid[0];
        for (int k = 1; k < NSTAGES; k++) begin
            n_valid[k] = rdy[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ctl.en        = rdy[NSTAGES-1:0];
    assign o_ctl.out_valid = r_valid[NSTAGES-1];
    assign o_ctl.in_ready  = rdy[0];

endmodule

### hw/rtl/bezier_point_evaluator.sv
// Top level of the cubic Bezier point evaluator (de Casteljau, three interpolation levels).
//
// Usage:
//   Control points are written through i_cfg_we / i_cfg_index / i_cfg_data, one signed
//   16-bit coordinate per write (x0, y0, x1, y1, ... x3, y3); other indexes are ignored.
//   Write them only while no transaction is in flight.
//   Each input transaction carries t in unsigned Q1.16 on i_curve_param; values above
//   1.0 are treated as 1.0. Each one yields one output transaction (o_point_x, o_point_y).
// Timing:
//   Seven register stages: clamp, then a multiply stage and a round/add stage for each
//   of the three interpolation levels. One transaction is taken every cycle unless a stall
//   at the output has filled every stage; the per-level multiplier sets the stage depth.
// Reset:
//   Synchronous, active low; all stages are emptied and the control points return to zero.
// Stalls:
//   When i_out_ready is low the result holds and the stages fill up behind it; o_in_ready
//   drops only once every stage holds a transaction.
module bezier_point_evaluator
    import bpe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PARAM_W-1:0]   i_curve_param,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [COORD_W-1:0]   o_point_x,
    output logic [COORD_W-1:0]   o_point_y
);

    t_pipe_ctl ctl;
    t_coord    ctrl_x [NUM_PTS];
    t_coord    ctrl_y [NUM_PTS];
    t_coord    lvl1_x [NUM_PTS-1];
    t_coord    lvl1_y [NUM_PTS-1];
    t_coord    lvl2_x [NUM_PTS-2];
    t_coord    lvl2_y [NUM_PTS-2];
    t_coord    lvl3_x;
    t_coord    lvl3_y;

    logic [PARAM_W-1:0] n_t0;
    logic [PARAM_W-1:0] r_t0;
    logic [PARAM_W-1:0] r_t1;
    logic [PARAM_W-1:0] r_t2;
    logic [PARAM_W-1:0] r_t3;
    logic [PARAM_W-1:0] r_t4;

    bpe_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ctrl_x    (ctrl_x),
        .o_ctrl_y    (ctrl_y)
    );

    bpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl)
    );

    assign n_t0 = (i_curve_param > PARAM_ONE) ? PARAM_ONE : i_curve_param;

    // The parameter travels beside the data to feed each level's multiplier.
    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) r_t0 <= n_t0;
        if (ctl.en[1]) r_t1 <= r_t0;
        if (ctl.en[2]) r_t2 <= r_t1;
        if (ctl.en[3]) r_t3 <= r_t2;
        if (ctl.en[4]) r_t4 <= r_t3;
    end

    for (genvar j = 0; j < NUM_PTS - 1; j++) begin : g_lvl1
        bpe_lerp u_x (
            .i_clk (i_clk), .i_en_mul (ctl.en[1]), .i_en_add (ctl.en[2]),
            .i_a (ctrl_x[j]), .i_b (ctrl_x[j+1]), .i_t (r_t0), .o_result (lvl1_x[j])
        );
        bpe_lerp u_y (
            .i_clk (i_clk), .i_en_mul (ctl.en[1]), .i_en_add (ctl.en[2]),
            .i_a (ctrl_y[j]), .i_b (ctrl_y[j+1]), .i_t (r_t0), .o_result (lvl1_y[j])
        );
    end

    for (genvar j = 0; j < NUM_PTS - 2; j++) begin : g_lvl2
        bpe_lerp u_x (
            .i_clk (i_clk), .i_en_mul (ctl.en[3]), .i_en_add (ctl.en[4]),
            .i_a (lvl1_x[j]), .i_b (lvl1_x[j+1]), .i_t (r_t2), .o_result (lvl2_x[j])
        );
        bpe_lerp u_y (
            .i_clk (i_clk), .i_en_mul (ctl.en[3]), .i_en_add (ctl.en[4]),
            .i_a (lvl1_y[j]), .i_b (lvl1_y[j+1]), .i_t (r_t2), .o_result (lvl2_y[j])
        );
    end

    bpe_lerp u_lvl3_x (
        .i_clk (i_clk), .i_en_mul (ctl.en[5]), .i_en_add (ctl.en[6]),
        .i_a (lvl2_x[0]), .i_b (lvl2_x[1]), .i_t (r_t4), .o_result (lvl3_x)
    );
    bpe_lerp u_lvl3_y (
        .i_clk (i_clk), .i_en_mul (ctl.en[5]), .i_en_add (ctl.en[6]),
        .i_a (lvl2_y[0]), .i_b (lvl2_y[1]), .i_t (r_t4), .o_result (lvl3_y)
    );

    assign o_in_ready  = ctl.in_ready;
    assign o_out_valid = ctl.out_valid;
    assign o_point_x   = lvl3_x;
    assign o_point_y   = lvl3_y;

endmodule

### hw/rtl/bpe_checker.sv
// Port-level checks for the Bezier point evaluator, bound to the top level.
module bpe_checker
    import bpe_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [COORD_W-1:0]   o_point_x,
    input logic [COORD_W-1:0]   o_point_y
);

    // Reset empties the pipeline, so no result shows the cycle after it.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Input back-pressure only happens when every stage is full behind a stalled output.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while output can drain");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_point_x) && $stable(o_point_y))
        else $error("output point changed while stalled");

endmodule

bind bezier_point_evaluator bpe_checker u_bpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_point_x   (o_point_x),
    .o_point_y   (o_point_y)
);

### verif/bezier_point_evaluator_tb.sv
// Self-checking testbench for the cubic Bezier point evaluator: random curves, parameters and stalls.
module bezier_point_evaluator_tb;
    import bpe_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RST_CYCLES   = 3;
    localparam int HOLD_CYCLES  = 64;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 60;
    localparam int LIMIT_CYCLES = 200_000;
    localparam int MAX_REPORTS  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = '1;
    localparam logic [PARAM_W-1:0]   PARAM_MAX   = '1;
    localparam logic [COORD_W-1:0]   COORD_MIN   = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0]   COORD_MAX   = {1'b0, {(COORD_W-1){1'b1}}};

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_curve_point;

    // Tracks the control points written so far and the curve points still owed by the block.
    class curve_scoreboard;
        longint       ctrl_x[NUM_PTS];
        longint       ctrl_y[NUM_PTS];
        t_curve_point owed_points[$];
        int unsigned  mismatches;

        function new();
            foreach (ctrl_x[i]) begin
                ctrl_x[i] = 0;
                ctrl_y[i] = 0;
            end
            mismatches = 0;
        endfunction

        function void set_reg(int unsigned idx, logic [COORD_W-1:0] data);
            // Writes beyond the last coordinate register leave the curve untouched.
            if (idx >= NUM_REGS)
                return;
            if (idx % 2 == 1)
                ctrl_y[idx / 2] = longint'(t_coord'(data));
            else
                ctrl_x[idx / 2] = longint'(t_coord'(data));
        endfunction

        function longint lerp(longint a, longint b, longint t);
            return a + (((b - a) * t + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        endfunction

        function void note_param(logic [PARAM_W-1:0] raw);
            longint       t;
            longint       wx[NUM_PTS];
            longint       wy[NUM_PTS];
            t_curve_point pt;
            t = (raw > PARAM_ONE) ? longint'(PARAM_ONE) : longint'(raw);
            wx = ctrl_x;
            wy = ctrl_y;
            for (int lvl = 1; lvl < NUM_PTS; lvl++) begin
                for (int j = 0; j < NUM_PTS - lvl; j++) begin
                    wx[j] = lerp(wx[j], wx[j + 1], t);
                    wy[j] = lerp(wy[j], wy[j + 1], t);
                end
            end
            pt.x = t_coord'(wx[0]);
            pt.y = t_coord'(wy[0]);
            owed_points.push_back(pt);
        endfunction

        function void check_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
            t_curve_point pt;
            if (owed_points.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected point x=%0d y=%0d", $signed(x), $signed(y));
                return;
            end
            pt = owed_points.pop_front();
            if (pt.x !== x || pt.y !== y) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                             pt.x, pt.y, $signed(x), $signed(y));
            end
        endfunction

        function int unsigned pending();
            return owed_points.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COORD_W-1:0]   i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [PARAM_W-1:0]   i_curve_param;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [COORD_W-1:0]   o_point_x;
    logic [COORD_W-1:0]   o_point_y;

    curve_scoreboard sb = new();
    bit              no_idle  = 1'b0;
    bit              hold_off = 1'b0;

    bezier_point_evaluator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_curve_param (i_curve_param),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_point(o_point_x, o_point_y);
    end

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [PARAM_W-1:0] pick_param();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return PARAM_ONE;
        else if (r < 36)
            return PARAM_W'($urandom_range(int'(PARAM_ONE) + 1, int'(PARAM_MAX)));
        return PARAM_W'($urandom_range(0, int'(PARAM_ONE)));
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(bit corners);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (corners || r < 20)
            return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        else if (r < 30)
            return COORD_W'($urandom_range(0, 15) - 8);
        return COORD_W'($urandom);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Leaves valid high at the falling edge after acceptance so the next call can chain on.
    task automatic send_param(logic [PARAM_W-1:0] t, int unsigned gap);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_curve_param = t;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_param(t);
        @(negedge i_clk);
    endtask

    task automatic send_random(int unsigned count);
        repeat (count)
            send_param(pick_param(), (no_idle || $urandom_range(0, 1)) ? 0 : idle_len());
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (NSTAGES + 2) @(negedge i_clk);
    endtask

    task automatic load_curve(bit corners);
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(t_reg_idx'(i), pick_coord(corners));
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, int'(CFG_IDX_MAX))), COORD_W'($urandom));
    endtask

    // Receiver: random ready pattern, with one long hold-off on request.
    initial begin
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_off) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
            end else begin
                i_out_ready = 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                if (!no_idle) begin
                    i_out_ready = 1'b0;
                    repeat (idle_len()) @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_curve_param = '0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Control points still at their reset value of zero.
        send_param('0, 0);
        send_param(PARAM_ONE, 0);
        wait_idle();

        // Full-swing control points, then writes past the last register that must be ignored.
        write_reg(REG_P0_X, COORD_MIN);
        write_reg(REG_P0_Y, COORD_MAX);
        write_reg(REG_P1_X, COORD_MAX);
        write_reg(REG_P1_Y, COORD_MIN);
        write_reg(REG_P2_X, COORD_MAX);
        write_reg(REG_P2_Y, COORD_MAX);
        write_reg(REG_P3_X, COORD_MIN);
        write_reg(REG_P3_Y, COORD_MIN);
        write_reg(CFG_IDX_W'(NUM_REGS), COORD_MAX);
        write_reg(CFG_IDX_MAX, 16'h5a5a);
        send_param('0, 0);
        send_param(PARAM_W'(1), 0);
        send_param(PARAM_ONE >> 1, 0);
        send_param(PARAM_W'((PARAM_ONE >> 1) - 1), 1);
        send_param(PARAM_W'(PARAM_ONE - 1), 0);
        send_param(PARAM_ONE, 2);
        // Parameters above one clamp to the last control point.
        send_param(PARAM_W'(PARAM_ONE + 1), 0);
        send_param(PARAM_MAX, 0);
        send_param(PARAM_ONE | (PARAM_ONE >> 1), 0);
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            load_curve(ph == 1 || ph == RAND_PHASES - 1);
            no_idle = (ph == 2);
            send_random(PHASE_ITEMS);
            if (ph == 4) begin
                // Keep offering items while the output is held off so the pipeline fills.
                hold_off = 1'b1;
                while (hold_off)
                    send_param(pick_param(), 0);
            end
            no_idle = 1'b0;
            wait_idle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
